/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the Bezier shape classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CBSC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("cbsc assertion failed");
`define CBSC_ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("cbsc forbidden condition seen");
`else
`define CBSC_ASSERT(label, prop)
`define CBSC_ASSERT_NEVER(label, expr)
`endif
`endif

/* rtl/cbsc_pkg.sv */
// Shared types and codes of the Bezier shape classifier.
package cbsc_pkg;

   typedef logic [2:0] cls_type;
   typedef logic [1:0] sgn_type;
   typedef logic [1:0] pos_type;
   typedef logic [1:0] plan_type;

   localparam cls_type CLS_ARCH   = 3'd0;
   localparam cls_type CLS_SINGLE = 3'd1;
   localparam cls_type CLS_DOUBLE = 3'd2;
   localparam cls_type CLS_CUSP   = 3'd3;
   localparam cls_type CLS_LOOP   = 3'd4;
   localparam cls_type CLS_LINE   = 3'd5;

   localparam sgn_type SGN_ZERO = 2'd0;
   localparam sgn_type SGN_POS  = 2'd1;
   localparam sgn_type SGN_NEG  = 2'd2;

   localparam pos_type POS_BEFORE  = 2'd0;
   localparam pos_type POS_BETWEEN = 2'd1;
   localparam pos_type POS_AFTER   = 2'd2;

   // final: class known from signs; disc: needs discriminant;
   // point: needs curve point test, then discriminant
   localparam plan_type PLAN_FINAL = 2'd0;
   localparam plan_type PLAN_DISC  = 2'd1;
   localparam plan_type PLAN_POINT = 2'd2;

   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_IDX_BITS-1:0] REG_DET_TOL  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_DISC_TOL = 1'b1;

   typedef struct packed {
      sgn_type s012;
      sgn_type s123;
      sgn_type s013;
      sgn_type s023;
      pos_type k1;
      pos_type k2;
   } det_flags_type;

endpackage

/* rtl/cbsc_det.sv */
// Triangle determinants, tolerance signs and control point chord positions.
module cbsc_det #(
   parameter int COORD_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [31:0]                       det_tol,
   input  logic                              in_valid,
   input  logic signed [COORD_BITS-1:0]      in_x [4],
   input  logic signed [COORD_BITS-1:0]      in_y [4],
   output logic                              out_valid,
   output cbsc_pkg::det_flags_type           out_flags,
   output logic signed [2*COORD_BITS+2:0]    out_d012,
   output logic signed [2*COORD_BITS+2:0]    out_d013,
   output logic signed [2*COORD_BITS+2:0]    out_d023,
   output logic signed [COORD_BITS-1:0]      out_x [4],
   output logic signed [COORD_BITS-1:0]      out_y [4]
);
   localparam int EW = COORD_BITS + 1;
   localparam int PW = 2 * EW;
   localparam int DW = PW + 1;
   localparam int TW = ((DW > 33) ? DW : 33) + 1;

   logic                        v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [COORD_BITS-1:0] x1_ff [4], y1_ff [4], x2_ff [4], y2_ff [4];
   logic signed [COORD_BITS-1:0] x3_ff [4], y3_ff [4], x4_ff [4], y4_ff [4];
   logic signed [EW-1:0] dx10, dy10, dx20, dy20, dx30, dy30, dx21, dy21, dx31, dy31;
   logic signed [EW-1:0] dx03, dy03, dx13, dy13, dx23, dy23;
   logic signed [PW-1:0] m_in [16], m_ff [16];
   logic signed [DW-1:0] d_in [4], d_ff [4];
   logic                 np_in [4], np_ff [4];
   logic signed [DW-1:0] s_tmp [4];
   cbsc_pkg::det_flags_type flags_in, flags_ff;
   logic signed [DW-1:0] d012_ff, d013_ff, d023_ff;
   logic signed [TW-1:0] tol_s;

   function automatic cbsc_pkg::sgn_type sgn_tol(logic signed [TW-1:0] d,
                                                 logic signed [TW-1:0] tol);
      cbsc_pkg::sgn_type r;
      if (d > tol) r = cbsc_pkg::SGN_POS;
      else if (d < -tol) r = cbsc_pkg::SGN_NEG;
      else r = cbsc_pkg::SGN_ZERO;
      return r;
   endfunction

   function automatic cbsc_pkg::pos_type chord_k(logic np_before, logic np_after);
      cbsc_pkg::pos_type r;
      if (np_before) r = cbsc_pkg::POS_BEFORE;
      else if (np_after) r = cbsc_pkg::POS_AFTER;
      else r = cbsc_pkg::POS_BETWEEN;
      return r;
   endfunction

   // capture the beat
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= in_valid;
      x1_ff <= in_x;
      y1_ff <= in_y;
   end

   assign dx10 = EW'(x1_ff[1]) - EW'(x1_ff[0]);
   assign dy10 = EW'(y1_ff[1]) - EW'(y1_ff[0]);
   assign dx20 = EW'(x1_ff[2]) - EW'(x1_ff[0]);
   assign dy20 = EW'(y1_ff[2]) - EW'(y1_ff[0]);
   assign dx30 = EW'(x1_ff[3]) - EW'(x1_ff[0]);
   assign dy30 = EW'(y1_ff[3]) - EW'(y1_ff[0]);
   assign dx21 = EW'(x1_ff[2]) - EW'(x1_ff[1]);
   assign dy21 = EW'(y1_ff[2]) - EW'(y1_ff[1]);
   assign dx31 = EW'(x1_ff[3]) - EW'(x1_ff[1]);
   assign dy31 = EW'(y1_ff[3]) - EW'(y1_ff[1]);
   assign dx03 = EW'(x1_ff[0]) - EW'(x1_ff[3]);
   assign dy03 = EW'(y1_ff[0]) - EW'(y1_ff[3]);
   assign dx13 = EW'(x1_ff[1]) - EW'(x1_ff[3]);
   assign dy13 = EW'(y1_ff[1]) - EW'(y1_ff[3]);
   assign dx23 = EW'(x1_ff[2]) - EW'(x1_ff[3]);
   assign dy23 = EW'(y1_ff[2]) - EW'(y1_ff[3]);

   always_comb begin
      m_in[0]  = PW'(dx10) * PW'(dy20);
      m_in[1]  = PW'(dy10) * PW'(dx20);
      m_in[2]  = PW'(dx21) * PW'(dy31);
      m_in[3]  = PW'(dy21) * PW'(dx31);
      m_in[4]  = PW'(dx10) * PW'(dy30);
      m_in[5]  = PW'(dy10) * PW'(dx30);
      m_in[6]  = PW'(dx20) * PW'(dy30);
      m_in[7]  = PW'(dy20) * PW'(dx30);
      m_in[8]  = PW'(dx30) * PW'(dx10);
      m_in[9]  = PW'(dy30) * PW'(dy10);
      m_in[10] = PW'(dx03) * PW'(dx13);
      m_in[11] = PW'(dy03) * PW'(dy13);
      m_in[12] = PW'(dx30) * PW'(dx20);
      m_in[13] = PW'(dy30) * PW'(dy20);
      m_in[14] = PW'(dx03) * PW'(dx23);
      m_in[15] = PW'(dy03) * PW'(dy23);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      m_ff  <= m_in;
      x2_ff <= x1_ff;
      y2_ff <= y1_ff;
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         d_in[i]  = DW'(m_ff[2*i]) - DW'(m_ff[2*i+1]);
         s_tmp[i] = DW'(m_ff[8+2*i]) + DW'(m_ff[9+2*i]);
         np_in[i] = (s_tmp[i] <= 0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      d_ff  <= d_in;
      np_ff <= np_in;
      x3_ff <= x2_ff;
      y3_ff <= y2_ff;
   end

   assign tol_s = $signed(TW'(det_tol));

   always_comb begin
      flags_in.s012 = sgn_tol(TW'(d_ff[0]), tol_s);
      flags_in.s123 = sgn_tol(TW'(d_ff[1]), tol_s);
      flags_in.s013 = sgn_tol(TW'(d_ff[2]), tol_s);
      flags_in.s023 = sgn_tol(TW'(d_ff[3]), tol_s);
      flags_in.k1   = chord_k(np_ff[0], np_ff[1]);
      flags_in.k2   = chord_k(np_ff[2], np_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      flags_ff <= flags_in;
      d012_ff  <= d_ff[0];
      d013_ff  <= d_ff[2];
      d023_ff  <= d_ff[3];
      x4_ff    <= x3_ff;
      y4_ff    <= y3_ff;
   end

   assign out_valid = v4_ff;
   assign out_flags = flags_ff;
   assign out_d012  = d012_ff;
   assign out_d013  = d013_ff;
   assign out_d023  = d023_ff;
   assign out_x     = x4_ff;
   assign out_y     = y4_ff;

endmodule

/* rtl/cbsc_disc.sv */
// Inflection quadratic discriminant, split multipliers, class against tolerance.
module cbsc_disc #(
   parameter int DET_BITS  = 35,
   parameter int SIDE_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [31:0]                disc_tol,
   input  logic                       in_valid,
   input  logic signed [DET_BITS-1:0] in_d012,
   input  logic signed [DET_BITS-1:0] in_d013,
   input  logic signed [DET_BITS-1:0] in_d023,
   input  logic [SIDE_BITS-1:0]       in_side,
   output logic                       out_valid,
   output cbsc_pkg::cls_type          out_cls,
   output logic [SIDE_BITS-1:0]       out_side
);
   localparam int AW = DET_BITS + 3;
   localparam int H  = AW / 2;
   localparam int LW = AW + H + 1;
   localparam int HW = 2 * AW - H;
   localparam int PW = 2 * AW + 3;

   logic                 v1_ff, v2_ff, v3_ff;
   logic [SIDE_BITS-1:0] side1_ff, side2_ff, side3_ff;
   logic signed [AW-1:0] a_in, b_in, a_ff, b_ff, c_ff;
   logic signed [LW-1:0] bl_in, al_in, bl_ff, al_ff;
   logic signed [HW-1:0] bh_in, ah_in, bh_ff, ah_ff;
   logic signed [PW-1:0] bb, ac, d, tol_s;
   cbsc_pkg::cls_type    cls_in, cls_ff;

   assign a_in = AW'(in_d012) * AW'(3) + AW'(in_d023) - (AW'(in_d013) <<< 1);
   assign b_in = AW'(in_d013) - AW'(in_d012) * AW'(3);

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= in_valid;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= AW'(in_d012);
      side1_ff <= in_side;
   end

   // low half unsigned, high half signed
   assign bl_in = LW'(b_ff) * LW'($signed({1'b0, b_ff[H-1:0]}));
   assign bh_in = HW'(b_ff) * HW'(b_ff >>> H);
   assign al_in = LW'(a_ff) * LW'($signed({1'b0, c_ff[H-1:0]}));
   assign ah_in = HW'(a_ff) * HW'(c_ff >>> H);

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      bl_ff    <= bl_in;
      bh_ff    <= bh_in;
      al_ff    <= al_in;
      ah_ff    <= ah_in;
      side2_ff <= side1_ff;
   end

   assign bb    = PW'(bl_ff) + (PW'(bh_ff) <<< H);
   assign ac    = PW'(al_ff) + (PW'(ah_ff) <<< H);
   assign d     = bb - (ac <<< 2);
   assign tol_s = $signed(PW'(disc_tol));

   always_comb begin
      if (d > tol_s) cls_in = cbsc_pkg::CLS_DOUBLE;
      else if (d < -tol_s) cls_in = cbsc_pkg::CLS_LOOP;
      else cls_in = cbsc_pkg::CLS_CUSP;
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      cls_ff   <= cls_in;
      side3_ff <= side2_ff;
   end

   assign out_valid = v3_ff;
   assign out_cls   = cls_ff;
   assign out_side  = side3_ff;

endmodule

/* rtl/cbsc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, for the split parameter.
module cbsc_div #(
   parameter int NUM_BITS  = 35,
   parameter int FRAC_BITS = 16,
   parameter int SIDE_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [NUM_BITS-1:0]  in_num,
   input  logic [NUM_BITS:0]    in_den,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_valid,
   output logic [FRAC_BITS-1:0] out_t,
   output logic [SIDE_BITS-1:0] out_side
);
   localparam int RW = NUM_BITS + 1;

   logic                 vld_ff  [FRAC_BITS];
   logic [RW-1:0]        rem_ff  [FRAC_BITS], rem_in [FRAC_BITS], rem_prev [FRAC_BITS];
   logic [RW-1:0]        den_ff  [FRAC_BITS], den_prev [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_ff    [FRAC_BITS], q_in [FRAC_BITS], q_prev [FRAC_BITS];
   logic [SIDE_BITS-1:0] side_ff [FRAC_BITS];
   logic                 guard;

   // a zero divisor or a quotient of one or more yields zero
   assign guard = (in_den == '0) || (RW'(in_num) >= in_den);

   always_comb begin
      logic [RW:0] sh;
      logic        ge;
      for (int i = 0; i < FRAC_BITS; i++) begin
         if (i == 0) begin
            rem_prev[i] = guard ? '0 : RW'(in_num);
            den_prev[i] = guard ? RW'(1) : in_den;
            q_prev[i]   = '0;
         end else begin
            rem_prev[i] = rem_ff[i-1];
            den_prev[i] = den_ff[i-1];
            q_prev[i]   = q_ff[i-1];
         end
         sh        = {rem_prev[i], 1'b0};
         ge        = (sh >= {1'b0, den_prev[i]});
         rem_in[i] = ge ? RW'(sh - {1'b0, den_prev[i]}) : RW'(sh);
         q_in[i]   = {q_prev[i][FRAC_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < FRAC_BITS; i++) begin
         if (reset) vld_ff[i] <= 1'b0;
         else vld_ff[i] <= (i == 0) ? in_valid : vld_ff[i-1];
         side_ff[i] <= (i == 0) ? in_side : side_ff[i-1];
         rem_ff[i]  <= rem_in[i];
         den_ff[i]  <= den_prev[i];
         q_ff[i]    <= q_in[i];
      end
   end

   assign out_valid = vld_ff[FRAC_BITS-1];
   assign out_t     = q_ff[FRAC_BITS-1];
   assign out_side  = side_ff[FRAC_BITS-1];

endmodule

/* rtl/cbsc_eval.sv */
// De Casteljau curve point at t and its position against the chord.
module cbsc_eval #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16,
   parameter int SIDE_BITS  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [FRAC_BITS-1:0]         in_t,
   input  logic signed [COORD_BITS-1:0] in_x [4],
   input  logic signed [COORD_BITS-1:0] in_y [4],
   input  logic [SIDE_BITS-1:0]         in_side,
   output logic                         out_valid,
   output logic                         out_between,
   output logic [SIDE_BITS-1:0]         out_side
);
   localparam int VW  = COORD_BITS + FRAC_BITS + 1;
   localparam int DFW = VW + 1;
   localparam int TSW = FRAC_BITS + 1;
   localparam int PRW = DFW + TSW;
   localparam int UW  = COORD_BITS + 1;
   localparam int DTW = UW + DFW;

   logic                         v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [SIDE_BITS-1:0]         sd1_ff, sd2_ff, sd3_ff, sd4_ff, sd5_ff;
   logic [FRAC_BITS-1:0]         t1_ff, t2_ff;
   logic signed [COORD_BITS-1:0] c0 [2][4], c1_ff [2][4], c2_ff [2][4], c3_ff [2][4];
   logic signed [PRW-1:0]        p1_in [2][3], p1_ff [2][3];
   logic signed [PRW-1:0]        p2_in [2][2], p2_ff [2][2];
   logic signed [PRW-1:0]        p3_in [2], p3_ff [2];
   logic signed [VW-1:0]         r_in [2][3], r2_ff [2][2], s_in [2][2], s0_ff [2], pt [2];
   logic signed [DTW-1:0]        mb_in [2], ma_in [2], mb_ff [2], ma_ff [2];
   logic signed [DTW:0]          sb, sa;
   logic                         btw_ff;

   function automatic logic signed [PRW-1:0] lerp_mul(logic signed [VW-1:0] a,
                                                      logic signed [VW-1:0] b,
                                                      logic [FRAC_BITS-1:0] t);
      logic signed [DFW-1:0] dd;
      dd = DFW'(b) - DFW'(a);
      return PRW'(dd) * PRW'($signed({1'b0, t}));
   endfunction

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         c0[0][i] = in_x[i];
         c0[1][i] = in_y[i];
      end
      for (int a = 0; a < 2; a++)
         for (int j = 0; j < 3; j++)
            p1_in[a][j] = lerp_mul(VW'(c0[a][j]) <<< FRAC_BITS,
                                   VW'(c0[a][j+1]) <<< FRAC_BITS, in_t);
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= in_valid;
      p1_ff  <= p1_in;
      c1_ff  <= c0;
      t1_ff  <= in_t;
      sd1_ff <= in_side;
   end

   // floor division by the scale is an arithmetic shift
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         for (int j = 0; j < 3; j++)
            r_in[a][j] = (VW'(c1_ff[a][j]) <<< FRAC_BITS) + VW'(p1_ff[a][j] >>> FRAC_BITS);
         for (int j = 0; j < 2; j++)
            p2_in[a][j] = lerp_mul(r_in[a][j], r_in[a][j+1], t1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      for (int a = 0; a < 2; a++) begin
         r2_ff[a][0] <= r_in[a][0];
         r2_ff[a][1] <= r_in[a][1];
      end
      p2_ff  <= p2_in;
      c2_ff  <= c1_ff;
      t2_ff  <= t1_ff;
      sd2_ff <= sd1_ff;
   end

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         for (int j = 0; j < 2; j++)
            s_in[a][j] = r2_ff[a][j] + VW'(p2_ff[a][j] >>> FRAC_BITS);
         p3_in[a] = lerp_mul(s_in[a][0], s_in[a][1], t2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      for (int a = 0; a < 2; a++) s0_ff[a] <= s_in[a][0];
      p3_ff  <= p3_in;
      c3_ff  <= c2_ff;
      sd3_ff <= sd2_ff;
   end

   // dot products scaled down by one factor of the scale; signs are unchanged
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         pt[a]    = s0_ff[a] + VW'(p3_ff[a] >>> FRAC_BITS);
         mb_in[a] = DTW'(UW'(c3_ff[a][3]) - UW'(c3_ff[a][0]))
                  * DTW'(DFW'(pt[a]) - DFW'(VW'(c3_ff[a][0]) <<< FRAC_BITS));
         ma_in[a] = DTW'(UW'(c3_ff[a][0]) - UW'(c3_ff[a][3]))
                  * DTW'(DFW'(pt[a]) - DFW'(VW'(c3_ff[a][3]) <<< FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      mb_ff  <= mb_in;
      ma_ff  <= ma_in;
      sd4_ff <= sd3_ff;
   end

   assign sb = (DTW+1)'(mb_ff[0]) + (DTW+1)'(mb_ff[1]);
   assign sa = (DTW+1)'(ma_ff[0]) + (DTW+1)'(ma_ff[1]);

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else v5_ff <= v4_ff;
      btw_ff <= (sb > 0) && (sa > 0);
      sd5_ff <= sd4_ff;
   end

   assign out_valid   = v5_ff;
   assign out_between = btw_ff;
   assign out_side    = sd5_ff;

endmodule

/* rtl/cubic_bezier_shape_classifier.sv */
// Throughput: one curve per cycle; busy stays low and start is taken on every cycle.
// The depth is set by the divider, one quotient bit per stage, T_FRAC_BITS stages.
// Reset (synchronous, active high) clears all valid bits and both tolerance registers.
// Each result is shown for exactly one cycle with rsp_valid; the receiver cannot stall.
// Top level: cubic Bezier curve shape classifier.
`include "assert_macros.svh"
module cubic_bezier_shape_classifier #(
   parameter int COORD_BITS  = 16,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [COORD_BITS-1:0]           req_p0_x,
   input  logic signed [COORD_BITS-1:0]           req_p0_y,
   input  logic signed [COORD_BITS-1:0]           req_p1_x,
   input  logic signed [COORD_BITS-1:0]           req_p1_y,
   input  logic signed [COORD_BITS-1:0]           req_p2_x,
   input  logic signed [COORD_BITS-1:0]           req_p2_y,
   input  logic signed [COORD_BITS-1:0]           req_p3_x,
   input  logic signed [COORD_BITS-1:0]           req_p3_y,
   output logic                                   rsp_valid,
   output logic [2:0]                             rsp_curve_class,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cbsc_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [cbsc_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   localparam int C   = COORD_BITS;
   localparam int DW  = 2 * C + 3;
   localparam int CW  = 8 * C;
   localparam int SW1 = CW + 2 * DW + 6;
   localparam int SW2 = CW + 8;
   localparam int SW3 = 8;
   localparam int LAT = T_FRAC_BITS + 13;

   // tolerance registers; the user must write them only while the pipeline is empty, the block does not enforce it
   logic [31:0] det_tol_ff, disc_tol_ff;

   logic signed [C-1:0] in_x [4], in_y [4];
   logic                     dt_valid;
   cbsc_pkg::det_flags_type  dt_flags;
   logic signed [DW-1:0]     dt_d012, dt_d013, dt_d023;
   logic signed [C-1:0]      dt_x [4], dt_y [4];

   cbsc_pkg::plan_type pl_plan;
   cbsc_pkg::cls_type  pl_fcls;
   logic [DW-1:0]      num, mag023;
   logic [DW:0]        den;
   logic [CW-1:0]      dt_coords;

   logic               ds_valid;
   cbsc_pkg::cls_type  ds_cls;
   logic [SW1-1:0]     ds_side;

   logic               dv_valid;
   logic [T_FRAC_BITS-1:0] dv_t;
   logic [SW2-1:0]     dv_side;
   logic signed [C-1:0] dv_x [4], dv_y [4];

   logic               ev_valid, ev_between;
   logic [SW3-1:0]     ev_side;
   cbsc_pkg::plan_type ev_plan;
   cbsc_pkg::cls_type  ev_fcls, ev_dcls, cls_in;

   logic               rsp_valid_ff;
   cbsc_pkg::cls_type  rsp_class_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // register writes; a write is one beat on the csr channel
   always_ff @(posedge clock) begin
      if (reset) begin
         det_tol_ff  <= '0;
         disc_tol_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cbsc_pkg::REG_DET_TOL:  det_tol_ff  <= csr_wdata;
            cbsc_pkg::REG_DISC_TOL: disc_tol_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign in_x[0] = req_p0_x;
   assign in_y[0] = req_p0_y;
   assign in_x[1] = req_p1_x;
   assign in_y[1] = req_p1_y;
   assign in_x[2] = req_p2_x;
   assign in_y[2] = req_p2_y;
   assign in_x[3] = req_p3_x;
   assign in_y[3] = req_p3_y;

   // stages 1-4: determinants, tolerance signs and integer chord positions
   cbsc_det #(.COORD_BITS(C)) u_det (
      .clock     (clock),
      .reset     (reset),
      .det_tol   (det_tol_ff),
      .in_valid  (start && !busy),
      .in_x      (in_x),
      .in_y      (in_y),
      .out_valid (dt_valid),
      .out_flags (dt_flags),
      .out_d012  (dt_d012),
      .out_d013  (dt_d013),
      .out_d023  (dt_d023),
      .out_x     (dt_x),
      .out_y     (dt_y)
   );

   // Decide from the signs which path gives the class. Collinear cases come
   // first, then the control polygon shape: zig-zag is a single inflection,
   // convex an arch, self-intersecting goes to the discriminant, and a concave
   // polygon needs the curve point test first.
   always_comb begin
      pl_plan = cbsc_pkg::PLAN_FINAL;
      pl_fcls = cbsc_pkg::CLS_ARCH;
      if (dt_flags.s012 == cbsc_pkg::SGN_ZERO && dt_flags.s123 == cbsc_pkg::SGN_ZERO) begin
         pl_fcls = (dt_flags.s013 == cbsc_pkg::SGN_ZERO) ? cbsc_pkg::CLS_LINE
                                                         : cbsc_pkg::CLS_ARCH;
      end else if (dt_flags.s012 == cbsc_pkg::SGN_ZERO) begin
         pl_fcls = (dt_flags.s013 == dt_flags.s123) ? cbsc_pkg::CLS_ARCH
                                                    : cbsc_pkg::CLS_SINGLE;
      end else if (dt_flags.s123 == cbsc_pkg::SGN_ZERO) begin
         pl_fcls = (dt_flags.s023 == dt_flags.s012) ? cbsc_pkg::CLS_ARCH
                                                    : cbsc_pkg::CLS_SINGLE;
      end else if (dt_flags.s013 == cbsc_pkg::SGN_ZERO) begin
         // P1 on the chord line
         case (dt_flags.k1)
            cbsc_pkg::POS_BEFORE:  pl_fcls = cbsc_pkg::CLS_ARCH;
            cbsc_pkg::POS_BETWEEN: pl_fcls = cbsc_pkg::CLS_SINGLE;
            default:               pl_plan = cbsc_pkg::PLAN_DISC;
         endcase
      end else if (dt_flags.s023 == cbsc_pkg::SGN_ZERO) begin
         // P2 on the chord line
         case (dt_flags.k2)
            cbsc_pkg::POS_AFTER:   pl_fcls = cbsc_pkg::CLS_ARCH;
            cbsc_pkg::POS_BETWEEN: pl_fcls = cbsc_pkg::CLS_SINGLE;
            default:               pl_plan = cbsc_pkg::PLAN_DISC;
         endcase
      end else if (dt_flags.s012 != dt_flags.s123) begin
         pl_fcls = cbsc_pkg::CLS_SINGLE;
      end else if (dt_flags.s012 == dt_flags.s013 && dt_flags.s012 == dt_flags.s023) begin
         pl_fcls = cbsc_pkg::CLS_ARCH;
      end else if (dt_flags.s012 != dt_flags.s013 && dt_flags.s012 != dt_flags.s023) begin
         pl_plan = cbsc_pkg::PLAN_DISC;
      end else begin
         pl_plan = cbsc_pkg::PLAN_POINT;
      end
   end

   // split parameter operands: |D013| over |D013| + |D023|
   assign num    = dt_d013[DW-1] ? DW'(-dt_d013) : DW'(dt_d013);
   assign mag023 = dt_d023[DW-1] ? DW'(-dt_d023) : DW'(dt_d023);
   assign den    = (DW+1)'(num) + (DW+1)'(mag023);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         dt_coords[(2*i)*C +: C]   = dt_x[i];
         dt_coords[(2*i+1)*C +: C] = dt_y[i];
      end
   end

   // stages 5-7: discriminant; plan, divider operands and coordinates ride along
   cbsc_disc #(.DET_BITS(DW), .SIDE_BITS(SW1)) u_disc (
      .clock     (clock),
      .reset     (reset),
      .disc_tol  (disc_tol_ff),
      .in_valid  (dt_valid),
      .in_d012   (dt_d012),
      .in_d013   (dt_d013),
      .in_d023   (dt_d023),
      .in_side   ({pl_plan, pl_fcls, num, den, dt_coords}),
      .out_valid (ds_valid),
      .out_cls   (ds_cls),
      .out_side  (ds_side)
   );

   // next T_FRAC_BITS stages: one quotient bit each
   cbsc_div #(.NUM_BITS(DW), .FRAC_BITS(T_FRAC_BITS), .SIDE_BITS(SW2)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ds_valid),
      .in_num    (ds_side[CW+DW+1 +: DW]),
      .in_den    (ds_side[CW +: DW+1]),
      .in_side   ({ds_side[CW+2*DW+1 +: 5], ds_cls, ds_side[CW-1:0]}),
      .out_valid (dv_valid),
      .out_t     (dv_t),
      .out_side  (dv_side)
   );

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         dv_x[i] = dv_side[(2*i)*C +: C];
         dv_y[i] = dv_side[(2*i+1)*C +: C];
      end
   end

   // next five stages: curve point at t and its chord position
   cbsc_eval #(.COORD_BITS(C), .FRAC_BITS(T_FRAC_BITS), .SIDE_BITS(SW3)) u_eval (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dv_valid),
      .in_t        (dv_t),
      .in_x        (dv_x),
      .in_y        (dv_y),
      .in_side     (dv_side[CW +: SW3]),
      .out_valid   (ev_valid),
      .out_between (ev_between),
      .out_side    (ev_side)
   );

   assign ev_dcls = ev_side[2:0];
   assign ev_fcls = ev_side[5:3];
   assign ev_plan = ev_side[7:6];

   // pick the class by plan
   always_comb begin
      case (ev_plan)
         cbsc_pkg::PLAN_FINAL: cls_in = ev_fcls;
         cbsc_pkg::PLAN_DISC:  cls_in = ev_dcls;
         cbsc_pkg::PLAN_POINT: cls_in = ev_between ? ev_dcls : cbsc_pkg::CLS_ARCH;
         default:              cls_in = cbsc_pkg::CLS_ARCH;
      endcase
   end

   // output register; one beat per accepted curve
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= ev_valid;
      rsp_class_ff <= cls_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_curve_class = rsp_class_ff;

   `CBSC_ASSERT(a_fixed_latency, (start && !busy) |-> ##LAT rsp_valid)
   `CBSC_ASSERT(a_eval_to_out, ev_valid |=> rsp_valid)
   `CBSC_ASSERT_NEVER(a_class_code, rsp_valid && (rsp_curve_class > cbsc_pkg::CLS_LINE))

endmodule

/* bench/tb_cubic_bezier_shape_classifier.sv */
// Self-checking testbench for the cubic Bezier shape classifier.
module tb_cubic_bezier_shape_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [127:0] wide_type;
   typedef logic signed [15:0] coord_type;
   typedef struct {
      coord_type x [4];
      coord_type y [4];
   } curve_type;

   localparam int FRAC = 16;
   localparam int DRAIN_CYCLES = 40;   // pipeline depth is 29 at default parameters

   logic clock;
   logic reset;
   logic start;
   logic busy;
   coord_type req_p0_x, req_p0_y, req_p1_x, req_p1_y;
   coord_type req_p2_x, req_p2_y, req_p3_x, req_p3_y;
   logic rsp_valid;
   logic [2:0] rsp_curve_class;
   logic csr_valid;
   logic csr_ready;
   logic [cbsc_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [cbsc_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   cubic_bezier_shape_classifier u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_p0_x(req_p0_x), .req_p0_y(req_p0_y), .req_p1_x(req_p1_x), .req_p1_y(req_p1_y),
      .req_p2_x(req_p2_x), .req_p2_y(req_p2_y), .req_p3_x(req_p3_x), .req_p3_y(req_p3_y),
      .rsp_valid(rsp_valid), .rsp_curve_class(rsp_curve_class),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Tolerances as the block should hold them.
   logic [31:0] det_tol;
   logic [31:0] disc_tol;

   curve_type         curves_pending [$];
   cbsc_pkg::cls_type classes_due [$];
   int        idle_pct;
   int        error_count;
   int        curves_sent;
   int        class_seen [6];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------- predictor
   function automatic int tol_sign(input wide_type d);
      if (d > wide_type'(det_tol)) return 1;
      if (d < -wide_type'(det_tol)) return -1;
      return 0;
   endfunction

   function automatic wide_type tri_area(input wide_type ax, ay, bx, by, cx, cy);
      return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
   endfunction

   // Discriminant of the inflection quadratic splits double inflection, cusp and loop.
   function automatic cbsc_pkg::cls_type disc_class(input wide_type d012, d013, d023);
      wide_type qa, qb, d;
      qa = 3 * d012 + d023 - 2 * d013;
      qb = d013 - 3 * d012;
      d = qb * qb - 4 * qa * d012;
      if (d > wide_type'(disc_tol)) return cbsc_pkg::CLS_DOUBLE;
      if (d < -wide_type'(disc_tol)) return cbsc_pkg::CLS_LOOP;
      return cbsc_pkg::CLS_CUSP;
   endfunction

   // Where q falls along chord a-b: before a, between, or past b.
   function automatic cbsc_pkg::pos_type chord_side(input wide_type ax, ay, bx, by, qx, qy);
      if ((bx - ax) * (qx - ax) + (by - ay) * (qy - ay) <= 0) return cbsc_pkg::POS_BEFORE;
      if ((ax - bx) * (qx - bx) + (ay - by) * (qy - by) <= 0) return cbsc_pkg::POS_AFTER;
      return cbsc_pkg::POS_BETWEEN;
   endfunction

   // Step toward b by t, rounding toward minus infinity.
   function automatic wide_type blend(input wide_type a, b, t);
      return a + (((b - a) * t) >>> FRAC);
   endfunction

   function automatic wide_type curve_point(input wide_type c0, c1, c2, c3, t);
      wide_type r0, r1, r2, s0, s1;
      r0 = blend(c0 <<< FRAC, c1 <<< FRAC, t);
      r1 = blend(c1 <<< FRAC, c2 <<< FRAC, t);
      r2 = blend(c2 <<< FRAC, c3 <<< FRAC, t);
      s0 = blend(r0, r1, t);
      s1 = blend(r1, r2, t);
      return blend(s0, s1, t);
   endfunction

   function automatic cbsc_pkg::cls_type shape_of(input curve_type c);
      wide_type x [4];
      wide_type y [4];
      wide_type d012, d123, d013, d023, num, den, t, px, py;
      int s012, s123, s013, s023;
      cbsc_pkg::pos_type k;
      for (int i = 0; i < 4; i++) begin
         x[i] = c.x[i];
         y[i] = c.y[i];
      end
      d012 = tri_area(x[0], y[0], x[1], y[1], x[2], y[2]);
      d123 = tri_area(x[1], y[1], x[2], y[2], x[3], y[3]);
      d013 = tri_area(x[0], y[0], x[1], y[1], x[3], y[3]);
      d023 = tri_area(x[0], y[0], x[2], y[2], x[3], y[3]);
      s012 = tol_sign(d012);
      s123 = tol_sign(d123);
      s013 = tol_sign(d013);
      s023 = tol_sign(d023);
      // collinear cases first
      if (s012 == 0 && s123 == 0)
         return (s013 == 0) ? cbsc_pkg::CLS_LINE : cbsc_pkg::CLS_ARCH;
      if (s012 == 0) return (s013 == s123) ? cbsc_pkg::CLS_ARCH : cbsc_pkg::CLS_SINGLE;
      if (s123 == 0) return (s023 == s012) ? cbsc_pkg::CLS_ARCH : cbsc_pkg::CLS_SINGLE;
      if (s013 == 0) begin
         k = chord_side(x[0], y[0], x[3], y[3], x[1], y[1]);
         if (k == cbsc_pkg::POS_BEFORE) return cbsc_pkg::CLS_ARCH;
         if (k == cbsc_pkg::POS_BETWEEN) return cbsc_pkg::CLS_SINGLE;
         return disc_class(d012, d013, d023);
      end
      if (s023 == 0) begin
         k = chord_side(x[0], y[0], x[3], y[3], x[2], y[2]);
         if (k == cbsc_pkg::POS_AFTER) return cbsc_pkg::CLS_ARCH;
         if (k == cbsc_pkg::POS_BETWEEN) return cbsc_pkg::CLS_SINGLE;
         return disc_class(d012, d013, d023);
      end
      // control polygon: zig-zag, convex, crossing, concave
      if (s012 != s123) return cbsc_pkg::CLS_SINGLE;
      if (s012 == s013 && s012 == s023) return cbsc_pkg::CLS_ARCH;
      if (s012 != s013 && s012 != s023) return disc_class(d012, d013, d023);
      num = (d013 < 0) ? -d013 : d013;
      den = num + ((d023 < 0) ? -d023 : d023);
      t = (den == 0 || num >= den) ? 0 : (num <<< FRAC) / den;
      px = curve_point(x[0], x[1], x[2], x[3], t);
      py = curve_point(y[0], y[1], y[2], y[3], t);
      if (chord_side(x[0] <<< FRAC, y[0] <<< FRAC, x[3] <<< FRAC, y[3] <<< FRAC,
                     px, py) == cbsc_pkg::POS_BETWEEN)
         return disc_class(d012, d013, d023);
      return cbsc_pkg::CLS_ARCH;
   endfunction

   // ------------------------------------------------------------ driver/monitor
   // Take beats and check results at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            classes_due.push_back(shape_of(curves_pending[0]));
            void'(curves_pending.pop_front());
         end
         if (rsp_valid) begin
            if (classes_due.size() == 0) begin
               report($sformatf("unexpected class %0d", rsp_curve_class));
            end else begin
               if (rsp_curve_class !== classes_due[0])
                  report($sformatf("curve_class %0d, expected %0d",
                                   rsp_curve_class, classes_due[0]));
               if (classes_due[0] <= cbsc_pkg::CLS_LINE) class_seen[classes_due[0]]++;
               void'(classes_due.pop_front());
            end
         end
      end
   end

   // Present the next curve at the falling edge unless the sender idles.
   always @(negedge clock) begin
      if (!reset && curves_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
         start    <= 1'b1;
         req_p0_x <= curves_pending[0].x[0];
         req_p0_y <= curves_pending[0].y[0];
         req_p1_x <= curves_pending[0].x[1];
         req_p1_y <= curves_pending[0].y[1];
         req_p2_x <= curves_pending[0].x[2];
         req_p2_y <= curves_pending[0].y[2];
         req_p3_x <= curves_pending[0].x[3];
         req_p3_y <= curves_pending[0].y[3];
      end else begin
         start <= 1'b0;
      end
   end

   // ----------------------------------------------------------------- stimulus
   task automatic write_reg(input logic [cbsc_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == cbsc_pkg::REG_DET_TOL) det_tol = value;
      else disc_tol = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_curve(input int ax, ay, bx, by, cx, cy, dx, dy);
      curve_type c;
      c.x[0] = coord_type'(ax); c.y[0] = coord_type'(ay);
      c.x[1] = coord_type'(bx); c.y[1] = coord_type'(by);
      c.x[2] = coord_type'(cx); c.y[2] = coord_type'(cy);
      c.x[3] = coord_type'(dx); c.y[3] = coord_type'(dy);
      curves_pending.push_back(c);
      curves_sent++;
   endtask

   // Mix full-range noise with small and collinear shapes that reach the rare cases.
   task automatic add_random_curve();
      curve_type c;
      int bx, by, ux, uy, m, span;
      m = $urandom_range(9);
      span = (m < 7) ? 3 + $urandom_range(60) : 0;
      for (int i = 0; i < 4; i++) begin
         if (m >= 7) begin
            c.x[i] = coord_type'($urandom);
            c.y[i] = coord_type'($urandom);
         end else begin
            c.x[i] = coord_type'($signed($urandom_range(2 * span)) - span);
            c.y[i] = coord_type'($signed($urandom_range(2 * span)) - span);
         end
      end
      if (m < 3) begin
         // put some points on one line through a random base
         bx = $signed($urandom_range(200)) - 100;
         by = $signed($urandom_range(200)) - 100;
         ux = $signed($urandom_range(8)) - 4;
         uy = $signed($urandom_range(8)) - 4;
         for (int i = 0; i < 4; i++) begin
            if (m == 0 || i != m) begin
               c.x[i] = coord_type'(bx + ux * ($signed($urandom_range(20)) - 10));
               c.y[i] = coord_type'(by + uy * ($signed($urandom_range(20)) - 10));
            end
         end
      end
      curves_pending.push_back(c);
      curves_sent++;
   endtask

   task automatic drain();
      while (curves_pending.size() != 0 || classes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [31:0] det_set [6];
      logic [31:0] disc_set [6];
      int idle_set [6];
      det_set  = '{32'd0, 32'd0, 32'd5, 32'hFFFF_FFFF, 32'd200, 32'd1};
      disc_set = '{32'd0, 32'd0, 32'd5000, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF};
      idle_set = '{0, 74, 38, 0, 74, 38};
      error_count = 0;
      curves_sent = 0;
      idle_pct = 0;
      det_tol = '0;
      disc_tol = '0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = cbsc_pkg::REG_DET_TOL;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed curves at reset tolerances.
      add_curve(0, 0, 0, 0, 0, 0, 0, 0);                  // degenerate point: line
      add_curve(0, 0, 1, 1, 2, 2, 3, 3);                  // straight line
      add_curve(0, 0, 1, 2, 3, 2, 4, 0);                  // convex arch
      add_curve(0, 0, 1, 2, 3, -2, 4, 0);                 // zig-zag: single inflection
      add_curve(0, 0, 4, 4, 0, 4, 4, 0);                  // crossing polygon: cusp
      add_curve(0, 0, 3, 3, 0, 3, 3, 0);                  // crossing polygon
      add_curve(0, 0, 10, 10, -6, 10, 4, 0);              // crossing polygon
      add_curve(0, 0, 2, 10, -20, 10, 10, 0);             // crossing polygon
      add_curve(0, 0, 1, 0, 2, 3, 5, 1);                  // zig-zag: single inflection
      add_curve(0, 0, 2, 3, 4, 0, 6, -3);                 // last three collinear
      add_curve(0, 0, 2, 0, 3, 2, 4, 0);                  // P1 on chord between ends
      add_curve(0, 0, -2, 0, 3, 2, 4, 0);                 // P1 on chord before P0
      add_curve(0, 0, 6, 0, 3, 2, 4, 0);                  // P1 on chord past P3
      add_curve(0, 0, 1, 2, 2, 0, 4, 0);                  // P2 on chord between ends
      add_curve(0, 0, 1, 2, 6, 0, 4, 0);                  // P2 on chord past P3
      add_curve(0, 0, 3, 3, 1, 3, 4, 0);                  // near-cusp shape
      add_curve(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      add_curve(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
      add_curve(-32768, 0, 0, 32767, 0, 32767, 32767, 0);
      add_curve(-1, -1, -1, -1, -1, -1, -1, -1);
      drain();

      // Random phases over tolerance settings and sender idling.
      for (int p = 0; p < 6; p++) begin
         write_reg(cbsc_pkg::REG_DET_TOL, det_set[p]);
         write_reg(cbsc_pkg::REG_DISC_TOL, disc_set[p]);
         idle_pct = idle_set[p];
         for (int n = 0; n < 80; n++) add_random_curve();
         drain();
      end
      // Repeat two directed shapes at the widest determinant tolerance.
      write_reg(cbsc_pkg::REG_DET_TOL, 32'hFFFF_FFFF);
      write_reg(cbsc_pkg::REG_DISC_TOL, 32'd0);
      idle_pct = 0;
      add_curve(0, 0, 4, 4, 0, 4, 4, 0);
      add_curve(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      drain();
      if (classes_due.size() != 0) report("results still outstanding at end");

      $display("Sent %0d curves: directed shapes, six random tolerance phases, wide tolerances.",
               curves_sent);
      $display("Classes seen: arch %0d single %0d double %0d cusp %0d loop %0d line %0d",
               class_seen[0], class_seen[1], class_seen[2], class_seen[3],
               class_seen[4], class_seen[5]);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/cbsc_pkg.sv
rtl/cbsc_det.sv
rtl/cbsc_disc.sv
rtl/cbsc_div.sv
rtl/cbsc_eval.sv
rtl/cubic_bezier_shape_classifier.sv
bench/tb_cubic_bezier_shape_classifier.sv
